/* hdl/sdpg_pkg.sv */
package sdpg_pkg;

    localparam int MAX_CH        = 4;
    localparam int POS_W         = 32;
    localparam int CMD_W         = 2;
    localparam int DEF_CHANNELS  = 4;
    localparam int DEF_PHASE_BIT = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] vel;
        logic             phase_latch;
        logic             sign_latch;
        logic             next_rising;
        logic             step;
        logic             dir;
    } t_chan_state;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             step;
        logic             dir;
    } t_chan_out;

    localparam t_chan_state CLEAR_STATE = '{
        pos:         '0,
        vel:         '0,
        phase_latch: 1'b0,
        sign_latch:  1'b0,
        next_rising: 1'b1,
        step:        1'b0,
        dir:         1'b0
    };

    localparam t_chan_out ZERO_OUT = '{position: '0, step: 1'b0, dir: 1'b0};

endpackage

/* hdl/sdpg_if.sv */
interface sdpg_in_if;
    import sdpg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [POS_W-1:0] velocity_0;
    logic signed [POS_W-1:0] velocity_1;
    logic signed [POS_W-1:0] velocity_2;
    logic signed [POS_W-1:0] velocity_3;

    modport source (output valid, command, velocity_0, velocity_1, velocity_2, velocity_3,
                    input ready);
    modport sink   (input valid, command, velocity_0, velocity_1, velocity_2, velocity_3,
                    output ready);
endinterface

interface sdpg_out_if;
    import sdpg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position_0;
    logic signed [POS_W-1:0] position_1;
    logic signed [POS_W-1:0] position_2;
    logic signed [POS_W-1:0] position_3;
    logic                    step_pin_0;
    logic                    step_pin_1;
    logic                    step_pin_2;
    logic                    step_pin_3;
    logic                    dir_pin_0;
    logic                    dir_pin_1;
    logic                    dir_pin_2;
    logic                    dir_pin_3;

    modport source (output valid, position_0, position_1, position_2, position_3,
                    step_pin_0, step_pin_1, step_pin_2, step_pin_3,
                    dir_pin_0, dir_pin_1, dir_pin_2, dir_pin_3,
                    input ready);
    modport sink   (input valid, position_0, position_1, position_2, position_3,
                    step_pin_0, step_pin_1, step_pin_2, step_pin_3,
                    dir_pin_0, dir_pin_1, dir_pin_2, dir_pin_3,
                    output ready);
endinterface

/* hdl/sdpg_channel.sv */
module sdpg_channel #(
    parameter int PHASE_BIT = sdpg_pkg::DEF_PHASE_BIT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  sdpg_pkg::t_cmd               i_cmd,
    input  logic [sdpg_pkg::POS_W-1:0]   i_velocity,
    output sdpg_pkg::t_chan_out          o_nxt
);
    import sdpg_pkg::*;

    t_chan_state r_st;
    t_chan_state n_st;
    logic        w_phase;
    logic        w_edge;
    logic        w_sign;

    assign w_phase = r_st.pos[PHASE_BIT];
    assign w_edge  = (w_phase != r_st.phase_latch);
    assign w_sign  = r_st.vel[POS_W-1];

    always_comb begin
        n_st = r_st;
        unique case (i_cmd)
            CMD_TICK: begin
                n_st.pos = r_st.pos + r_st.vel;
                if (w_edge) begin
                    n_st.phase_latch = w_phase;
                    n_st.next_rising = ~r_st.next_rising;
                    n_st.step        = r_st.next_rising;
                    // falling edge: re-check direction against the velocity sign
                    if (!r_st.next_rising && (w_sign != r_st.sign_latch)) begin
                        n_st.sign_latch = w_sign;
                        if (w_sign) begin
                            n_st.dir = 1'b1;
                        end else if (r_st.vel != '0) begin
                            n_st.dir = 1'b0;
                        end
                    end
                end
            end
            CMD_LOAD:  n_st.vel = i_velocity;
            CMD_CLEAR: n_st = CLEAR_STATE;
            default:   n_st = r_st;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= CLEAR_STATE;
        end else if (i_adv) begin
            r_st <= n_st;
        end
    end

    assign o_nxt = '{position: n_st.pos, step: n_st.step, dir: n_st.dir};

endmodule

/* hdl/step_dir_pulse_generator_core.sv */
// Each accepted input word passes from the input register through the channel update
// into the result register.
// Throughput: one word per cycle when not stalled; each channel is one 32-bit adder and
// a few bit compares. While a result word waits, one more input word is taken into the
// input register, then the input side stalls until the result word is taken.
// Reset: synchronous active-low clears all channel state (positions, velocities, pins)
// and empties both register stages.
module step_dir_pulse_generator_core #(
    parameter int CHANNELS  = sdpg_pkg::DEF_CHANNELS,
    parameter int PHASE_BIT = sdpg_pkg::DEF_PHASE_BIT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdpg_in_if.sink    i_in,
    sdpg_out_if.source o_out
);
    import sdpg_pkg::*;

    // Input register stage
    logic             r_in_valid;
    t_cmd             r_cmd;
    logic [POS_W-1:0] r_vel [MAX_CH];

    // Result register stage
    logic             r_out_valid;
    t_chan_out        r_out [MAX_CH];

    logic             w_adv;
    t_chan_out        w_nxt [MAX_CH];

    // Advance the input word into the channels when the result register is free
    // or is being emptied this cycle.
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Payload: capture on acceptance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd    <= t_cmd'(i_in.command);
            r_vel[0] <= i_in.velocity_0;
            r_vel[1] <= i_in.velocity_1;
            r_vel[2] <= i_in.velocity_2;
            r_vel[3] <= i_in.velocity_3;
        end
    end

    // One update unit per configured channel; unused channels report zero.
    for (genvar k = 0; k < MAX_CH; k++) begin : g_ch
        if (k < CHANNELS) begin : g_on
            sdpg_channel #(
                .PHASE_BIT (PHASE_BIT)
            ) u_channel (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_adv      (w_adv),
                .i_cmd      (r_cmd),
                .i_velocity (r_vel[k]),
                .o_nxt      (w_nxt[k])
            );
        end else begin : g_off
            assign w_nxt[k] = ZERO_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result word holds the channel state as left by the command
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < MAX_CH; k++) begin
                r_out[k] <= w_nxt[k];
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.position_0 = r_out[0].position;
    assign o_out.position_1 = r_out[1].position;
    assign o_out.position_2 = r_out[2].position;
    assign o_out.position_3 = r_out[3].position;
    assign o_out.step_pin_0 = r_out[0].step;
    assign o_out.step_pin_1 = r_out[1].step;
    assign o_out.step_pin_2 = r_out[2].step;
    assign o_out.step_pin_3 = r_out[3].step;
    assign o_out.dir_pin_0  = r_out[0].dir;
    assign o_out.dir_pin_1  = r_out[1].dir;
    assign o_out.dir_pin_2  = r_out[2].dir;
    assign o_out.dir_pin_3  = r_out[3].dir;

    // A word moved into the channels must appear in the result register next cycle.
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced word missing from result register");

    // A held input word with a stalled result must block further input.
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while pipeline stalled");

    // A clear command reports channel 0 at rest.
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_cmd == CMD_CLEAR) |=>
            (r_out[0].position == '0 && !r_out[0].step && !r_out[0].dir))
        else $error("clear command left channel state");

endmodule
